// File: rtl/cfp_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the colon field request parser.
// No dependencies; used by every module of the block by scoped names.
package cfp_pkg;

    // Field length at which too_long is raised; length counters saturate here.
    localparam int unsigned FIELD_MAX = 1024;
    localparam int unsigned LEN_W     = $clog2(FIELD_MAX + 1);

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned NUM_W   = 32;
    localparam int unsigned IDX_W   = 16;
    localparam int unsigned KIND_W  = 3;

    // Queue between front and back.
    localparam int unsigned QDEPTH  = 2;
    localparam int unsigned QPTR_W  = $clog2(QDEPTH);
    localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

    // Character codes.
    localparam logic [BYTE_W-1:0] CHAR_COLON  = 8'h3A;
    localparam logic [BYTE_W-1:0] CHAR_EQUALS = 8'h3D;
    localparam logic [BYTE_W-1:0] CHAR_ZERO   = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE   = 8'h39;

    // Parser phases, also the field_kind codes.
    localparam logic [KIND_W-1:0] PH_TIME    = 3'd0;
    localparam logic [KIND_W-1:0] PH_SERVICE = 3'd1;
    localparam logic [KIND_W-1:0] PH_PAIRCNT = 3'd2;
    localparam logic [KIND_W-1:0] PH_PAIR    = 3'd3;
    localparam logic [KIND_W-1:0] PH_NAMECNT = 3'd4;
    localparam logic [KIND_W-1:0] PH_NAME    = 3'd5;
    localparam logic [KIND_W-1:0] PH_DONE    = 3'd6;

    // A request byte after classification.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              last;
        logic              is_colon;
        logic              is_equals;
        logic              is_digit;
        logic [3:0]        digit;
    } item_t;

    // Queue status seen by front and back.
    typedef struct packed {
        logic full;
        logic not_empty;
    } qstat_t;

    // One result.
    typedef struct packed {
        logic [KIND_W-1:0] field_kind;
        logic [BYTE_W-1:0] text_byte;
        logic              is_value_part;
        logic              field_end;
        logic [NUM_W-1:0]  number_value;
        logic [IDX_W-1:0]  entry_index;
        logic              pair_error;
        logic              too_long;
        logic              message_end;
    } res_t;

endpackage

// File: rtl/colon_field_request_parser_unit.sv
`timescale 1ns / 1ps
// Top level of the colon field request parser: front, queue and back end.
// Depends on cfp_pkg, cfp_front, cfp_queue and cfp_back.
//
//  channel   direction  handshake             payload
//  request   in         req_valid/req_stall   in_byte, last_byte
//  result    out        res_valid/res_stall   field_kind .. message_end
//
// One request byte is taken per cycle while req_stall is low, and each gives
// exactly one result. The byte is written into the two-entry queue at the
// accepting edge; once it is at the head and the result register is free, the
// back end pops it, updates its state and loads the result register. The
// sustained rate of one byte per cycle, with neither side stalled, is set by
// the combinational state update (multiply-by-ten add and compares).
// rst_n clears the queue, the parser state (timestamp phase) and res_valid.
// A stalled result holds in its register; the queue keeps taking bytes until
// both of its entries are used, then req_stall rises, and each side stalls
// independently.
module colon_field_request_parser_unit
(
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [cfp_pkg::BYTE_W-1:0]    in_byte,
    input  logic                          last_byte,

    output logic                          res_valid,
    input  logic                          res_stall,
    output logic [cfp_pkg::KIND_W-1:0]    field_kind,
    output logic [cfp_pkg::BYTE_W-1:0]    text_byte,
    output logic                          is_value_part,
    output logic                          field_end,
    output logic [cfp_pkg::NUM_W-1:0]     number_value,
    output logic [cfp_pkg::IDX_W-1:0]     entry_index,
    output logic                          pair_error,
    output logic                          too_long,
    output logic                          message_end
);

    cfp_pkg::qstat_t qstat;
    cfp_pkg::item_t  wr_item;
    cfp_pkg::item_t  rd_item;
    cfp_pkg::res_t   res;
    logic            push;
    logic            pop;

    // classify incoming bytes, stall only on a full queue
    cfp_front u_front
    (
        .req_valid (req_valid),
        .req_stall (req_stall),
        .in_byte   (in_byte),
        .last_byte (last_byte),
        .qstat     (qstat),
        .push      (push),
        .item      (wr_item)
    );

    cfp_queue u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (wr_item),
        .pop     (pop),
        .rd_item (rd_item),
        .qstat   (qstat)
    );

    // parse state and result register
    cfp_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .item      (rd_item),
        .pop       (pop),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res       (res)
    );

    assign field_kind    = res.field_kind;
    assign text_byte     = res.text_byte;
    assign is_value_part = res.is_value_part;
    assign field_end     = res.field_end;
    assign number_value  = res.number_value;
    assign entry_index   = res.entry_index;
    assign pair_error    = res.pair_error;
    assign too_long      = res.too_long;
    assign message_end   = res.message_end;

    // a pair error is only reported on the colon closing a pair
    a_pair_error_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && pair_error) |-> (field_end && field_kind == cfp_pkg::PH_PAIR))
        else $error("pair_error outside a pair terminator");

    // value bytes belong to a pair and never to its colon
    a_value_in_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && is_value_part) |-> (!field_end && field_kind == cfp_pkg::PH_PAIR))
        else $error("is_value_part outside pair body");

    // done bytes carry nothing but message_end
    a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && field_kind == cfp_pkg::PH_DONE) |->
        (text_byte == '0 && number_value == '0 && entry_index == '0 &&
         !field_end && !too_long))
        else $error("done result with payload");

    // after a completed message the next result starts in the timestamp field
    a_restart_time: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !res_stall && message_end) ##1 res_valid |->
        (field_kind == cfp_pkg::PH_TIME))
        else $error("parser did not restart after last byte");

endmodule

// File: rtl/cfp_front.sv
`timescale 1ns / 1ps
// Front end: takes request bytes and classifies them for the back end.
// Depends on cfp_pkg.
module cfp_front
(
    input  logic                        req_valid,
    output logic                        req_stall,
    input  logic [cfp_pkg::BYTE_W-1:0]  in_byte,
    input  logic                        last_byte,
    input  cfp_pkg::qstat_t             qstat,
    output logic                        push,
    output cfp_pkg::item_t              item
);

    assign req_stall = qstat.full;
    assign push      = req_valid && !qstat.full;

    always_comb
    begin
        item.data      = in_byte;
        item.last      = last_byte;
        item.is_colon  = (in_byte == cfp_pkg::CHAR_COLON);
        item.is_equals = (in_byte == cfp_pkg::CHAR_EQUALS);
        item.is_digit  = (in_byte >= cfp_pkg::CHAR_ZERO) && (in_byte <= cfp_pkg::CHAR_NINE);
        item.digit     = 4'(in_byte - cfp_pkg::CHAR_ZERO);
    end

endmodule

// File: rtl/cfp_queue.sv
`timescale 1ns / 1ps
// Short FIFO of classified bytes between front and back end.
// Depends on cfp_pkg.
module cfp_queue
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cfp_pkg::item_t  wr_item,
    input  logic            pop,
    output cfp_pkg::item_t  rd_item,
    output cfp_pkg::qstat_t qstat
);

    cfp_pkg::item_t                  store_reg [cfp_pkg::QDEPTH];
    logic [cfp_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [cfp_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [cfp_pkg::QCNT_W-1:0]      count_reg, count_next;

    function automatic logic [cfp_pkg::QPTR_W-1:0] ptr_inc(input logic [cfp_pkg::QPTR_W-1:0] p);
        logic [cfp_pkg::QPTR_W-1:0] r;
        if (32'(p) == cfp_pkg::QDEPTH - 1)
            r = '0;
        else
            r = p + 1'b1;
        return r;
    endfunction

    assign rd_item         = store_reg[rd_ptr_reg];
    assign qstat.full      = (32'(count_reg) == cfp_pkg::QDEPTH);
    assign qstat.not_empty = (count_reg != '0);

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            store_reg[wr_ptr_reg] <= wr_item;
    end

endmodule

// File: rtl/cfp_back.sv
`timescale 1ns / 1ps
// Back end: field state machine, number accumulation and result register.
// Depends on cfp_pkg.
module cfp_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfp_pkg::qstat_t qstat,
    input  cfp_pkg::item_t  item,
    output logic            pop,
    output logic            res_valid,
    input  logic            res_stall,
    output cfp_pkg::res_t   res
);

    logic [cfp_pkg::KIND_W-1:0] phase_reg,     phase_next;
    logic [cfp_pkg::NUM_W-1:0]  acc_reg,       acc_next;
    logic                       stopped_reg,   stopped_next;
    logic [cfp_pkg::IDX_W-1:0]  count_reg,     count_next;
    logic [cfp_pkg::IDX_W-1:0]  pos_reg,       pos_next;
    logic [cfp_pkg::LEN_W-1:0]  flen_reg,      flen_next;
    logic                       seen_eq_reg,   seen_eq_next;
    logic [cfp_pkg::LEN_W-1:0]  vlen_reg,      vlen_next;
    logic                       res_valid_reg, res_valid_next;
    cfp_pkg::res_t              res_reg,       res_next;

    logic                       numeric;
    logic                       listed;
    logic [cfp_pkg::LEN_W-1:0]  flen_inc;
    logic [cfp_pkg::LEN_W-1:0]  vlen_inc;
    logic [35:0]                acc_x10;
    logic [cfp_pkg::NUM_W-1:0]  acc_sat;
    logic [cfp_pkg::IDX_W-1:0]  cnt_sat;
    logic [cfp_pkg::IDX_W-1:0]  pos_inc;

    localparam logic [cfp_pkg::LEN_W-1:0] LEN_MAX = cfp_pkg::LEN_W'(cfp_pkg::FIELD_MAX);

    assign pop       = qstat.not_empty && (!res_valid_reg || !res_stall);
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        numeric  = (phase_reg == cfp_pkg::PH_TIME) || (phase_reg == cfp_pkg::PH_PAIRCNT) ||
                   (phase_reg == cfp_pkg::PH_NAMECNT);
        listed   = (phase_reg == cfp_pkg::PH_PAIR) || (phase_reg == cfp_pkg::PH_NAME);
        flen_inc = (flen_reg >= LEN_MAX) ? LEN_MAX : flen_reg + 1'b1;
        vlen_inc = (vlen_reg >= LEN_MAX) ? LEN_MAX : vlen_reg + 1'b1;
        // acc * 10 + digit as (acc << 3) + (acc << 1) + digit
        acc_x10  = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0} + 36'(item.digit);
        acc_sat  = (acc_x10[35:32] != 4'd0) ? '1 : acc_x10[31:0];
        cnt_sat  = (acc_reg[31:16] != 16'd0) ? '1 : acc_reg[15:0];
        pos_inc  = pos_reg + 1'b1;

        phase_next     = phase_reg;
        acc_next       = acc_reg;
        stopped_next   = stopped_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        flen_next      = flen_reg;
        seen_eq_next   = seen_eq_reg;
        vlen_next      = vlen_reg;
        res_valid_next = res_valid_reg && res_stall;
        res_next       = res_reg;

        if (pop)
        begin
            res_valid_next = 1'b1;
            res_next       = '0;
            res_next.message_end = item.last;
            if (phase_reg >= cfp_pkg::PH_DONE)
            begin
                res_next.field_kind = cfp_pkg::PH_DONE;
            end
            else
            begin
                res_next.field_kind = phase_reg;
                if (!numeric)
                    res_next.text_byte = item.data;
                if (listed)
                    res_next.entry_index = pos_reg;
                if (item.is_colon)
                begin
                    res_next.field_end = 1'b1;
                    res_next.too_long  = (flen_reg >= LEN_MAX);
                    if (numeric)
                    begin
                        res_next.number_value = acc_reg;
                        if (phase_reg == cfp_pkg::PH_TIME)
                        begin
                            phase_next = cfp_pkg::PH_SERVICE;
                        end
                        else
                        begin
                            count_next = cnt_sat;
                            pos_next   = '0;
                            // an empty list is skipped
                            phase_next = (cnt_sat == '0) ? phase_reg + 3'd2 : phase_reg + 3'd1;
                        end
                    end
                    else if (phase_reg == cfp_pkg::PH_SERVICE)
                    begin
                        phase_next = cfp_pkg::PH_PAIRCNT;
                    end
                    else
                    begin
                        if (phase_reg == cfp_pkg::PH_PAIR)
                            res_next.pair_error = !seen_eq_reg || (vlen_reg == '0);
                        pos_next = pos_inc;
                        if ((pos_inc == '0) || (pos_inc >= count_reg))
                        begin
                            pos_next   = '0;
                            phase_next = phase_reg + 3'd1;
                        end
                    end
                    acc_next     = '0;
                    stopped_next = 1'b0;
                    flen_next    = '0;
                    seen_eq_next = 1'b0;
                    vlen_next    = '0;
                end
                else
                begin
                    flen_next         = flen_inc;
                    res_next.too_long = (flen_inc >= LEN_MAX);
                    if (numeric)
                    begin
                        if (!stopped_reg && item.is_digit)
                            acc_next = acc_sat;
                        else
                            stopped_next = 1'b1;
                        res_next.number_value = (!stopped_reg && item.is_digit) ? acc_sat : acc_reg;
                    end
                    else if (phase_reg == cfp_pkg::PH_PAIR)
                    begin
                        if (seen_eq_reg)
                        begin
                            res_next.is_value_part = 1'b1;
                            vlen_next = vlen_inc;
                        end
                        else if (item.is_equals)
                        begin
                            seen_eq_next = 1'b1;
                        end
                    end
                end
            end
            if (item.last)
            begin
                phase_next   = cfp_pkg::PH_TIME;
                acc_next     = '0;
                stopped_next = 1'b0;
                count_next   = '0;
                pos_next     = '0;
                flen_next    = '0;
                seen_eq_next = 1'b0;
                vlen_next    = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= cfp_pkg::PH_TIME;
            acc_reg       <= '0;
            stopped_reg   <= 1'b0;
            count_reg     <= '0;
            pos_reg       <= '0;
            flen_reg      <= '0;
            seen_eq_reg   <= 1'b0;
            vlen_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            acc_reg       <= acc_next;
            stopped_reg   <= stopped_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            flen_reg      <= flen_next;
            seen_eq_reg   <= seen_eq_next;
            vlen_reg      <= vlen_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

endmodule
